@@ rtl/fram_pkg.sv @@
`default_nettype none

package fram_pkg;

    localparam int REG_IDX_W = 2;
    localparam int IMM_W     = 32;
    localparam int DATA_W    = 64;
    localparam int CNT_W     = 6;

    // Instruction operation codes
    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_OUTPUT = 3'd1,
        OP_ADD    = 3'd2,
        OP_SUB    = 3'd3,
        OP_MUL    = 3'd4,
        OP_MOVE   = 3'd5,
        OP_DIV    = 3'd6
    } t_op;

    // Result kinds
    localparam logic RK_OUTPUT   = 1'b0;
    localparam logic RK_DIV_ZERO = 1'b1;

    typedef struct packed {
        logic [2:0]                   operation;
        logic [REG_IDX_W-1:0]         dest_reg;
        logic                         src_is_reg;
        logic [REG_IDX_W-1:0]         src_reg;
        logic signed [IMM_W-1:0]      immediate;
    } t_instr;

    typedef struct packed {
        logic                         result_kind;
        logic signed [DATA_W-1:0]     value;
    } t_result;

    // Serial arithmetic unit operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [1:0] {
        AP_IDLE,
        AP_PREP,
        AP_LOOP,
        AP_FIX
    } t_alu_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

endpackage

`default_nettype wire

@@ rtl/fram_ram.sv @@
`default_nettype none

module fram_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr0,
    input  wire logic [AW-1:0]    i_raddr1,
    output logic      [WIDTH-1:0] o_rdata0,
    output logic      [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, read two with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

`default_nettype wire

@@ rtl/fram_alu.sv @@
`default_nettype none

module fram_alu
    import fram_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_alu_req          i_req,
    input  wire logic [DATA_W-1:0] i_a,
    input  wire logic [DATA_W-1:0] i_b,
    output logic                   o_done,
    output logic      [DATA_W-1:0] o_result
);

    t_alu_phase        r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_done, n_done;
    t_alu_op           r_op, n_op;
    logic [DATA_W-1:0] r_a, n_a;
    logic [DATA_W-1:0] r_b, n_b;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic              r_carry, n_carry;
    logic              r_neg, n_neg;

    logic              b_bit;
    logic              s_bit;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;

    // Per-bit add/subtract, shift-add multiply, restoring divide
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_op    = r_op;
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_carry = r_carry;
        n_neg   = r_neg;

        b_bit   = (r_op == ALU_SUB) ? ~r_b[0] : r_b[0];
        s_bit   = r_a[0] ^ b_bit ^ r_carry;
        shifted = {r_rem, r_a[DATA_W-1]};
        trial   = shifted - {1'b0, r_b};

        unique case (r_phase)
            AP_IDLE: begin
                if (i_req.start) begin
                    n_op    = i_req.op;
                    n_a     = i_a;
                    n_b     = i_b;
                    n_acc   = '0;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_carry = (i_req.op == ALU_SUB);
                    n_phase = (i_req.op == ALU_DIV) ? AP_PREP : AP_LOOP;
                end
            end
            AP_PREP: begin
                // Take magnitudes, remember the quotient sign
                n_a     = r_a[DATA_W-1] ? (DATA_W'(0) - r_a) : r_a;
                n_b     = r_b[DATA_W-1] ? (DATA_W'(0) - r_b) : r_b;
                n_neg   = r_a[DATA_W-1] ^ r_b[DATA_W-1];
                n_phase = AP_LOOP;
            end
            AP_LOOP: begin
                unique case (r_op)
                    ALU_ADD, ALU_SUB: begin
                        n_acc   = {s_bit, r_acc[DATA_W-1:1]};
                        n_carry = (r_a[0] & b_bit) | (r_a[0] & r_carry) | (b_bit & r_carry);
                        n_a     = r_a >> 1;
                        n_b     = r_b >> 1;
                    end
                    ALU_MUL: begin
                        if (r_b[0]) begin
                            n_acc = r_acc + r_a;
                        end
                        n_a = r_a << 1;
                        n_b = r_b >> 1;
                    end
                    ALU_DIV: begin
                        // One quotient bit per cycle, shifted into r_a
                        if (!trial[DATA_W]) begin
                            n_rem = trial[DATA_W-1:0];
                            n_a   = {r_a[DATA_W-2:0], 1'b1};
                        end else begin
                            n_rem = shifted[DATA_W-1:0];
                            n_a   = {r_a[DATA_W-2:0], 1'b0};
                        end
                    end
                    default: ;
                endcase
                n_cnt = r_cnt + 1'b1;
                if (&r_cnt) begin
                    n_cnt = '0;
                    if (r_op == ALU_DIV) begin
                        n_phase = AP_FIX;
                    end else begin
                        n_phase = AP_IDLE;
                        n_done  = 1'b1;
                    end
                end
            end
            AP_FIX: begin
                // Apply the quotient sign
                n_acc   = r_neg ? (DATA_W'(0) - r_a) : r_a;
                n_phase = AP_IDLE;
                n_done  = 1'b1;
            end
            default: n_phase = AP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= AP_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_a     <= n_a;
        r_b     <= n_b;
        r_acc   <= n_acc;
        r_rem   <= n_rem;
        r_carry <= n_carry;
        r_neg   <= n_neg;
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

    a_cnt_loop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != AP_LOOP) |-> (r_cnt == '0))
        else $error("bit counter running outside the loop phase");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_phase == AP_IDLE))
        else $error("done raised while the unit is still working");

    a_prep_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == AP_PREP) |-> (r_op == ALU_DIV))
        else $error("magnitude step entered for a non-divide operation");

endmodule

`default_nettype wire

@@ rtl/four_register_alu_machine.sv @@
`default_nettype none

// Four-register ALU machine: executes one decoded instruction at a time on a
// file of NUM_REGS signed 64-bit registers.
//
// Command channel: drive i_instr and raise start; the instruction transfers
// at the rising edge where start is high and busy is low. busy stays high
// until the instruction has finished and the register write has happened.
// Result channel: output and divide-by-zero instructions raise o_valid for
// exactly one cycle with o_result; the receiver cannot stall, so the result
// is taken at the end of that cycle.
//
// Timing: load, move, output and unused codes finish in the read state (the register
// file read is registered). Add and subtract run one bit per cycle through
// the serial unit, multiply one multiplier bit per cycle. Divide adds a
// magnitude step and a sign step; divide by zero finishes in the read state.
// The 64-step loop of the serial unit sets the rate.
//
// Reset clears all entry valid bits, so every register reads as zero until
// written, and returns the control to idle.
module four_register_alu_machine
    import fram_pkg::*;
#(
    parameter int NUM_REGS = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire t_instr  i_instr,
    output logic         busy,
    output logic         o_valid,
    output t_result      o_result
);

    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    function automatic logic [AW-1:0] to_addr(input logic [REG_IDX_W-1:0] idx);
        logic [AW+REG_IDX_W-1:0] wide;
        wide = {{AW{1'b0}}, idx};
        return wide[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [REG_IDX_W-1:0] idx);
        return 32'(idx) < NUM_REGS;
    endfunction

    t_state              r_state, n_state;
    t_instr              r_ins;
    logic                r_dok;
    logic                r_sok;
    logic [NUM_REGS-1:0] r_valid;
    logic                r_out_vld, n_out_vld;
    t_result             r_out, n_out;

    logic                accept;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [DATA_W-1:0]   wdata;
    logic [DATA_W-1:0]   rdata0;
    logic [DATA_W-1:0]   rdata1;
    logic [DATA_W-1:0]   d_val;
    logic [DATA_W-1:0]   s_reg;
    logic [DATA_W-1:0]   s_val;
    logic [DATA_W-1:0]   imm64;
    t_alu_req            alu_req;
    logic                alu_done;
    logic [DATA_W-1:0]   alu_result;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign waddr  = to_addr(r_ins.dest_reg);

    fram_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_REGS)
    ) u_regs (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (to_addr(i_instr.dest_reg)),
        .i_raddr1 (to_addr(i_instr.src_reg)),
        .o_rdata0 (rdata0),
        .o_rdata1 (rdata1)
    );

    fram_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (d_val),
        .i_b      (s_val),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    // Operand selection; unwritten or missing registers read as zero
    always_comb begin
        imm64 = {{(DATA_W-IMM_W){r_ins.immediate[IMM_W-1]}}, r_ins.immediate};
        d_val = r_dok ? rdata0 : '0;
        s_reg = r_sok ? rdata1 : '0;
        s_val = r_ins.src_is_reg ? s_reg : imm64;
    end

    // Decode, dispatch and write back
    always_comb begin
        n_state       = r_state;
        n_out_vld     = 1'b0;
        n_out         = r_out;
        we            = 1'b0;
        wdata         = alu_result;
        alu_req.start = 1'b0;
        alu_req.op    = ALU_ADD;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
                case (t_op'(r_ins.operation))
                    OP_LOAD: begin
                        we    = in_range(r_ins.dest_reg);
                        wdata = imm64;
                    end
                    OP_OUTPUT: begin
                        n_out_vld         = 1'b1;
                        n_out.result_kind = RK_OUTPUT;
                        n_out.value       = d_val;
                    end
                    OP_ADD: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = ALU_ADD;
                        n_state       = S_EXEC;
                    end
                    OP_SUB: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = ALU_SUB;
                        n_state       = S_EXEC;
                    end
                    OP_MUL: begin
                        alu_req.start = 1'b1;
                        alu_req.op    = ALU_MUL;
                        n_state       = S_EXEC;
                    end
                    OP_MOVE: begin
                        we    = in_range(r_ins.dest_reg);
                        wdata = s_reg;
                    end
                    OP_DIV: begin
                        if (s_val == '0) begin
                            n_out_vld         = 1'b1;
                            n_out.result_kind = RK_DIV_ZERO;
                            n_out.value       = '0;
                        end else begin
                            alu_req.start = 1'b1;
                            alu_req.op    = ALU_DIV;
                            n_state       = S_EXEC;
                        end
                    end
                    default: ;
                endcase
            end
            S_EXEC: begin
                if (alu_done) begin
                    we      = in_range(r_ins.dest_reg);
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, valid bits and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
        end
    end

    // Capture the instruction and its operand validity at transfer, and register the result value
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ins <= i_instr;
            r_dok <= in_range(i_instr.dest_reg) && r_valid[to_addr(i_instr.dest_reg)];
            r_sok <= in_range(i_instr.src_reg) && r_valid[to_addr(i_instr.src_reg)];
        end
        r_out <= n_out;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after an instruction transfer");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> busy)
        else $error("register write while idle");

    a_done_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state == S_EXEC))
        else $error("serial unit finished with no instruction waiting");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none

module tb_top
    import fram_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes and the one operation code the package leaves unnamed
    localparam logic [1:0] REG_A = 2'd0;
    localparam logic [1:0] REG_B = 2'd1;
    localparam logic [1:0] REG_C = 2'd2;
    localparam logic [1:0] REG_D = 2'd3;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam logic signed [DATA_W-1:0] INT64_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam int DIR_ROWS     = 25;
    localparam int RAND_ITEMS   = 950;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 400000;

    // One directed row: instruction plus an optional hand-written expectation
    typedef struct packed {
        t_instr  ins;
        logic    fixed_exp;
        t_result res;
    } t_dir_row;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_instr  i_instr = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    logic signed [DATA_W-1:0] shadow_regs [4];
    t_result  pending_results [$];
    int       mismatch_cnt = 0;
    int       cycle_cnt    = 0;
    t_dir_row dir_tab [DIR_ROWS];

    four_register_alu_machine #(
        .NUM_REGS (4)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_instr  (i_instr),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Execute one instruction on the shadow register file; return 1 if it emits
    function automatic bit run_instr(input t_instr ins, output t_result res);
        logic signed [DATA_W-1:0] d;
        logic signed [DATA_W-1:0] s;
        logic signed [DATA_W-1:0] imm64;
        begin
            res   = '0;
            imm64 = {{(DATA_W-IMM_W){ins.immediate[IMM_W-1]}}, ins.immediate};
            d     = shadow_regs[ins.dest_reg];
            s     = ins.src_is_reg ? shadow_regs[ins.src_reg] : imm64;
            run_instr = 1'b0;
            case (ins.operation)
                OP_LOAD: shadow_regs[ins.dest_reg] = imm64;
                OP_OUTPUT: begin
                    res.result_kind = RK_OUTPUT;
                    res.value       = d;
                    run_instr       = 1'b1;
                end
                OP_ADD: shadow_regs[ins.dest_reg] = d + s;
                OP_SUB: shadow_regs[ins.dest_reg] = d - s;
                OP_MUL: shadow_regs[ins.dest_reg] = d * s;
                OP_MOVE: shadow_regs[ins.dest_reg] = shadow_regs[ins.src_reg];
                OP_DIV: begin
                    if (s == 0) begin
                        res.result_kind = RK_DIV_ZERO;
                        res.value       = '0;
                        run_instr       = 1'b1;
                    end else if (d == INT64_MIN && s == -64'sd1) begin
                        // quotient overflows and wraps back to the most negative value
                        shadow_regs[ins.dest_reg] = INT64_MIN;
                    end else begin
                        shadow_regs[ins.dest_reg] = d / s;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    function automatic t_dir_row mk_row(input logic [2:0] op, input logic [1:0] dst,
                                        input logic is_reg, input logic [1:0] src,
                                        input logic [31:0] imm, input logic fixed,
                                        input logic kind, input logic [63:0] val);
        t_dir_row row;
        begin
            row.ins.operation       = op;
            row.ins.dest_reg        = dst;
            row.ins.src_is_reg      = is_reg;
            row.ins.src_reg         = src;
            row.ins.immediate       = imm;
            row.fixed_exp           = fixed;
            row.res.result_kind     = kind;
            row.res.value           = val;
            mk_row = row;
        end
    endfunction

    // Random instruction, weighted toward arithmetic and output
    function automatic t_instr draw_instr();
        t_instr ins;
        int     pick;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)      ins.operation = OP_LOAD;
            else if (pick < 30) ins.operation = OP_OUTPUT;
            else if (pick < 42) ins.operation = OP_ADD;
            else if (pick < 52) ins.operation = OP_SUB;
            else if (pick < 62) ins.operation = OP_MUL;
            else if (pick < 70) ins.operation = OP_MOVE;
            else if (pick < 96) ins.operation = OP_DIV;
            else                ins.operation = OP_UNUSED;
            ins.dest_reg   = 2'($urandom_range(0, 3));
            ins.src_is_reg = 1'($urandom_range(0, 1));
            ins.src_reg    = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 15))
                0:       ins.immediate = 32'h0000_0000;
                1:       ins.immediate = 32'hFFFF_FFFF;
                2:       ins.immediate = 32'h8000_0000;
                3:       ins.immediate = 32'h7FFF_FFFF;
                4, 5:    ins.immediate = $urandom_range(0, 16) - 8;
                default: ins.immediate = $urandom;
            endcase
            draw_instr = ins;
        end
    endfunction

    // Present one instruction, hold it until the transfer, then predict
    task automatic send_instr(input t_instr ins, input logic fixed, input t_result fixed_res);
        t_result res;
        bit      emits;
        begin
            i_instr <= ins;
            start   <= 1'b1;
            do @(posedge i_clk); while (busy);
            emits = run_instr(ins, res);
            if (fixed)
                res = fixed_res;
            if (emits)
                pending_results.push_back(res);
        end
    endtask

    // Idle the command side for a random count, with bursts of back-to-back items
    task automatic sender_gap(input int idx);
        int gap;
        begin
            gap = (idx % 64 < 16) ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Drop start and wait for every outstanding result
    task automatic hold_until_drained();
        begin
            start <= 1'b0;
            do @(posedge i_clk); while (pending_results.size() != 0);
        end
    endtask

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d value %0d", $time,
                         o_result.result_kind, o_result.value);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.result_kind !== want.result_kind) begin
                    $display("%0t: result_kind expected %0d actual %0d", $time,
                             want.result_kind, o_result.result_kind);
                    mismatch_cnt++;
                end
                if (o_result.value !== want.value) begin
                    $display("%0t: value expected %0d actual %0d", $time,
                             want.value, o_result.value);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin : stimulus
        int i;
        dir_tab = '{
            // reset state reads as zero
            mk_row(OP_OUTPUT, REG_A, 1'b0, REG_A, 32'd0, 1'b1, RK_OUTPUT, 64'd0),
            mk_row(OP_OUTPUT, REG_D, 1'b1, REG_B, 32'hFFFF_FFFF, 1'b1, RK_OUTPUT, 64'd0),
            // immediate extremes; load ignores the register form bit
            mk_row(OP_LOAD, REG_A, 1'b1, REG_D, 32'h7FFF_FFFF, 1'b0, RK_OUTPUT, 64'd0),
            mk_row(OP_OUTPUT, REG_A, 1'b0, REG_A, 32'd0, 1'b1, RK_OUTPUT,
                   64'h0000_0000_7FFF_FFFF),
            mk_row(OP_LOAD, REG_B, 1'b0, REG_A, 32'h8000_0000, 1'b0, RK_OUTPUT, 64'd0),
            mk_row(OP_OUTPUT, REG_B, 1'b0, REG_A, 32'd0, 1'b1, RK_OUTPUT,
                   64'hFFFF_FFFF_8000_0000),
            // divide by zero, immediate and register forms, leaves the destination
            mk_row(OP_DIV, REG_A, 1'b0, REG_B, 32'd0, 1'b1, RK_DIV_ZERO, 64'd0),
            mk_row(OP_DIV, REG_A, 1'b1, REG_D, 32'd5, 1'b1, RK_DIV_ZERO, 64'd0),
            mk_row(OP_OUTPUT, REG_A, 1'b0, REG_A, 32'd0, 1'b1, RK_OUTPUT,
                   64'h0000_0000_7FFF_FFFF),
            // build the most negative value by wrapping multiply
            mk_row(OP_MUL, REG_B, 1'b1, REG_B, 32'd0, 1'b0, RK_OUTPUT, 64'd0),
            mk_row(OP_MUL, REG_B, 1'b0, REG_A, 32'd2, 1'b0, RK_OUTPUT, 64'd0),
            mk_row(OP_OUTPUT, REG_B, 1'b0, REG_A, 32'd0, 1'b1, RK_OUTPUT,
                   64'h8000_0000_0000_0000),
            // most negative divided by -1 wraps
            mk_row(OP_DIV, REG_B, 1'b0, REG_A, 32'hFFFF_FFFF, 1'b0, RK_OUTPUT, 64'd0),
            mk_row(OP_OUTPUT, REG_B, 1'b0, REG_A, 32'd0, 1'b1, RK_OUTPUT,
                   64'h8000_0000_0000_0000),
            // subtract and add wrap across the signed range
            mk_row(OP_SUB, REG_B, 1'b0, REG_A, 32'd1, 1'b0, RK_OUTPUT, 64'd0),
            mk_row(OP_OUTPUT, REG_B, 1'b0, REG_A, 32'd0, 1'b1, RK_OUTPUT,
                   64'h7FFF_FFFF_FFFF_FFFF),
            mk_row(OP_ADD, REG_B, 1'b0, REG_A, 32'd1, 1'b0, RK_OUTPUT, 64'd0),
            // move ignores the register form bit
            mk_row(OP_MOVE, REG_C, 1'b0, REG_B, 32'd9, 1'b0, RK_OUTPUT, 64'd0),
            mk_row(OP_OUTPUT, REG_C, 1'b0, REG_A, 32'd0, 1'b0, RK_OUTPUT, 64'd0),
            // division truncates toward zero
            mk_row(OP_LOAD, REG_D, 1'b0, REG_A, 32'hFFFF_FFF9, 1'b0, RK_OUTPUT, 64'd0),
            mk_row(OP_DIV, REG_D, 1'b0, REG_A, 32'd2, 1'b0, RK_OUTPUT, 64'd0),
            mk_row(OP_OUTPUT, REG_D, 1'b0, REG_A, 32'd0, 1'b0, RK_OUTPUT, 64'd0),
            // unused code changes nothing
            mk_row(OP_UNUSED, REG_A, 1'b1, REG_B, 32'hFFFF_FFFF, 1'b0, RK_OUTPUT, 64'd0),
            mk_row(OP_ADD, REG_A, 1'b1, REG_B, 32'd0, 1'b0, RK_OUTPUT, 64'd0),
            mk_row(OP_OUTPUT, REG_A, 1'b0, REG_A, 32'd0, 1'b0, RK_OUTPUT, 64'd0)
        };
        for (i = 0; i < 4; i++)
            shadow_regs[i] = '0;

        // Hold reset, then release it
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < DIR_ROWS; i++) begin
            send_instr(dir_tab[i].ins, dir_tab[i].fixed_exp, dir_tab[i].res);
            sender_gap(i);
        end
        hold_until_drained();

        for (i = 0; i < RAND_ITEMS; i++) begin
            send_instr(draw_instr(), 1'b0, '0);
            sender_gap(i);
            if (i == RAND_ITEMS / 2)
                hold_until_drained();
        end

        // Wait out the last results, then allow for any stray one
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/fram_pkg.sv
rtl/fram_ram.sv
rtl/fram_alu.sv
rtl/four_register_alu_machine.sv
tb/sv/tb_top.sv
